>>> rtl/core/psirq_pkg.sv
package psirq_pkg;

    // number of pads that are wired up, and the slots the register page has for them
    localparam int PAD_COUNT = 2;
    localparam int PAD_SLOTS = 2;

    localparam int CTRL_W = 6;
    localparam int LATCH_W = 16;
    localparam int SHIFT_W = 8;
    localparam int IRQ_W = 8;
    localparam int LATCH_TOP_BIT = 15;

    // offsets within the register page
    localparam logic [7:0] OFF_SHIFT0 = 8'h02;
    localparam logic [7:0] OFF_SHIFT1 = 8'h03;
    localparam logic [7:0] OFF_SHIFT_CTRL = 8'h07;
    localparam logic [7:0] OFF_IRQ_EN = 8'h10;
    localparam logic [7:0] OFF_IRQ_SRC = 8'h11;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
        logic [2:0] source_bit;
        logic source_level;
        logic [15:0] pad_a_buttons;
        logic [15:0] pad_b_buttons;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic irq_line;
    } rsp_item_t;

endpackage

>>> rtl/core/psirq_ifs.sv
interface psirq_req_if;
    import psirq_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] source_bit;
    logic source_level;
    logic [15:0] pad_a_buttons;
    logic [15:0] pad_b_buttons;

    modport source (
        output valid, operation, reg_offset, write_data, source_bit, source_level,
               pad_a_buttons, pad_b_buttons,
        input ready
    );
    modport sink (
        input valid, operation, reg_offset, write_data, source_bit, source_level,
              pad_a_buttons, pad_b_buttons,
        output ready
    );
endinterface

interface psirq_rsp_if;
    logic valid;
    logic ready;
    logic [7:0] read_data;
    logic irq_line;

    modport source (
        output valid, read_data, irq_line,
        input ready
    );
    modport sink (
        input valid, read_data, irq_line,
        output ready
    );
endinterface

>>> rtl/core/psirq_regs.sv
module psirq_regs
    import psirq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  req_item_t item,
    output rsp_item_t result
);

    logic [CTRL_W-1:0] shift_control_reg, shift_control_next;
    logic [SHIFT_W-1:0] shift_reg [PAD_SLOTS];
    logic [SHIFT_W-1:0] shift_next [PAD_SLOTS];
    logic [LATCH_W-1:0] latch_reg [PAD_SLOTS];
    logic [LATCH_W-1:0] latch_next [PAD_SLOTS];
    logic [IRQ_W-1:0] irq_enable_reg, irq_enable_next;
    logic [IRQ_W-1:0] irq_source_reg, irq_source_next;

    logic [CTRL_W-1:0] fell;
    logic ctrl_write;
    logic [LATCH_W-1:0] pads [PAD_SLOTS];
    logic [7:0] rdata;

    assign pads[0] = item.pad_a_buttons;
    assign pads[1] = item.pad_b_buttons;

    assign ctrl_write = (item.operation == OP_WRITE) && (item.reg_offset == OFF_SHIFT_CTRL);
    assign fell = ctrl_write ? (shift_control_reg & ~item.write_data[CTRL_W-1:0])
                             : '0;

    always_comb
    begin
        shift_control_next = shift_control_reg;
        irq_enable_next = irq_enable_reg;
        irq_source_next = irq_source_reg;
        rdata = '0;
        for (int p = 0; p < PAD_SLOTS; p++)
        begin
            shift_next[p] = shift_reg[p];
            latch_next[p] = latch_reg[p];
        end

        case (item.operation)
            OP_READ:
            begin
                unique case (item.reg_offset)
                    OFF_SHIFT0: rdata = shift_reg[0];
                    OFF_SHIFT1: rdata = shift_reg[1];
                    OFF_IRQ_EN: rdata = irq_enable_reg;
                    OFF_IRQ_SRC:
                    begin
                        rdata = irq_source_reg;
                        irq_source_next = '0;
                    end
                    default: rdata = '0;
                endcase
            end
            OP_WRITE:
            begin
                unique case (item.reg_offset)
                    OFF_SHIFT_CTRL: shift_control_next = item.write_data[CTRL_W-1:0];
                    OFF_IRQ_EN: irq_enable_next = item.write_data;
                    default: ;
                endcase
            end
            OP_EVENT: irq_source_next[item.source_bit] = item.source_level;
            default: ;
        endcase

        // per pad: latch, then shift the top bit in, then clear
        for (int p = 0; p < PAD_SLOTS; p++)
        begin
            if (p < PAD_COUNT)
            begin
                if (fell[p])
                    latch_next[p] = pads[p];
                if (fell[p+2])
                begin
                    shift_next[p] = {shift_next[p][SHIFT_W-2:0], latch_next[p][LATCH_TOP_BIT]};
                    latch_next[p] = {latch_next[p][LATCH_W-2:0], 1'b0};
                end
                if (fell[p+4])
                    shift_next[p] = '0;
            end
        end
    end

    assign result.read_data = rdata;
    assign result.irq_line = |(irq_enable_next & irq_source_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_control_reg <= '0;
            irq_enable_reg <= '0;
            irq_source_reg <= '0;
            for (int p = 0; p < PAD_SLOTS; p++)
            begin
                shift_reg[p] <= '0;
                latch_reg[p] <= '0;
            end
        end
        else if (fire)
        begin
            shift_control_reg <= shift_control_next;
            irq_enable_reg <= irq_enable_next;
            irq_source_reg <= irq_source_next;
            for (int p = 0; p < PAD_SLOTS; p++)
            begin
                shift_reg[p] <= shift_next[p];
                latch_reg[p] <= latch_next[p];
            end
        end
    end

    a_src_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_READ && item.reg_offset == OFF_IRQ_SRC
        |=> irq_source_reg == '0)
        else $error("interrupt source not cleared by its read");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(shift_control_reg) && $stable(irq_enable_reg)
                  && $stable(irq_source_reg))
        else $error("register state moved without a beat");

    a_event_sets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.operation == OP_EVENT && item.source_level
        |=> irq_source_reg[$past(item.source_bit)])
        else $error("interrupt event did not set its source bit");

endmodule

>>> rtl/core/pad_shift_and_irq_registers_unit.sv
// channel | dir | beat carries
// --------+-----+----------------------------------------------------------------
// req     | in  | operation, reg_offset, write_data, source_bit, source_level, pads
// rsp     | out | read_data, irq_line (one per req beat, same order)
//
// one req beat is taken every cycle while rsp is not stalled; its rsp beat passes through the
// input register, then the register decode and state update into the result register
// the rate is set by that single pass: a beat makes all its state changes in it
// reset (rst_n low, asynchronous) clears both stage valids and all register state
// a stalled rsp holds its beat; req keeps flowing while the input stage can move on
module pad_shift_and_irq_registers_unit
    import psirq_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    psirq_req_if.sink    req,
    psirq_rsp_if.source  rsp
);

    req_item_t item_reg;
    req_item_t item_next;
    logic item_valid_reg;
    rsp_item_t rsp_reg;
    rsp_item_t result;
    logic rsp_valid_reg;

    logic advance;  // result register free or being emptied this cycle
    logic fire;     // the held item goes through the register page

    assign advance = !rsp_valid_reg || rsp.ready;
    assign fire = item_valid_reg && advance;
    assign req.ready = !item_valid_reg || advance;

    assign item_next.operation = req.operation;
    assign item_next.reg_offset = req.reg_offset;
    assign item_next.write_data = req.write_data;
    assign item_next.source_bit = req.source_bit;
    assign item_next.source_level = req.source_level;
    assign item_next.pad_a_buttons = req.pad_a_buttons;
    assign item_next.pad_b_buttons = req.pad_b_buttons;

    // register page: state lives here; read_data is from the state before the step, irq_line from the state after it
    psirq_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                item_valid_reg <= req.valid;
            if (advance)
                rsp_valid_reg <= item_valid_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            item_reg <= item_next;
        if (fire)
            rsp_reg <= result;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.read_data = rsp_reg.read_data;
    assign rsp.irq_line = rsp_reg.irq_line;

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("held request lost while result stalled");

    a_item_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("processed request produced no response beat");

    a_rsp_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled response beat changed");

endmodule

>>> tb/pad_shift_and_irq_registers_unit_checker.sv
module pad_shift_and_irq_registers_checker
    import psirq_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    psirq_req_if req,
    psirq_rsp_if rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the register page
    logic [CTRL_W-1:0]  ctrl_shadow;
    logic [SHIFT_W-1:0] shifter_shadow [PAD_SLOTS];
    logic [LATCH_W-1:0] latch_shadow [PAD_SLOTS];
    logic [IRQ_W-1:0]   enable_shadow;
    logic [IRQ_W-1:0]   source_shadow;

    rsp_item_t due_responses [$];
    int        fail_total = 0;
    int        in_flight = 0;

    assign mismatches = fail_total;
    assign outstanding = in_flight;

    // falling control bits: latch, then shift, then clear, per pad
    task automatic write_shift_control(input logic [7:0] value,
                                       input logic [LATCH_W-1:0] pad_a,
                                       input logic [LATCH_W-1:0] pad_b);
        logic [CTRL_W-1:0]  fell;
        logic [LATCH_W-1:0] pads [PAD_SLOTS];
        pads[0] = pad_a;
        pads[1] = pad_b;
        fell = ctrl_shadow & ~value[CTRL_W-1:0];
        ctrl_shadow = value[CTRL_W-1:0];
        for (int p = 0; p < PAD_COUNT && p < PAD_SLOTS; p++)
        begin
            if (fell[p])
                latch_shadow[p] = pads[p];
            if (fell[p + 2])
            begin
                shifter_shadow[p] = {shifter_shadow[p][SHIFT_W-2:0],
                                     latch_shadow[p][LATCH_TOP_BIT]};
                latch_shadow[p] = latch_shadow[p] << 1;
            end
            if (fell[p + 4])
                shifter_shadow[p] = '0;
        end
    endtask

    task automatic update_register_page(input req_item_t beat, output rsp_item_t res);
        logic [7:0] data;
        data = '0;
        case (beat.operation)
            OP_READ:
            begin
                if (beat.reg_offset == OFF_SHIFT0)
                    data = shifter_shadow[0];
                else if (beat.reg_offset == OFF_SHIFT1)
                    data = shifter_shadow[1];
                else if (beat.reg_offset == OFF_IRQ_EN)
                    data = enable_shadow;
                else if (beat.reg_offset == OFF_IRQ_SRC)
                begin
                    data = source_shadow;
                    source_shadow = '0;
                end
            end
            OP_WRITE:
            begin
                if (beat.reg_offset == OFF_SHIFT_CTRL)
                    write_shift_control(beat.write_data, beat.pad_a_buttons,
                                        beat.pad_b_buttons);
                else if (beat.reg_offset == OFF_IRQ_EN)
                    enable_shadow = beat.write_data;
            end
            OP_EVENT:
                source_shadow[beat.source_bit] = beat.source_level;
            default:
                ;
        endcase
        res.read_data = data;
        res.irq_line = |(enable_shadow & source_shadow);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        req_item_t beat;
        if (!rst_n)
        begin
            ctrl_shadow = '0;
            shifter_shadow[0] = '0;
            shifter_shadow[1] = '0;
            latch_shadow[0] = '0;
            latch_shadow[1] = '0;
            enable_shadow = '0;
            source_shadow = '0;
            due_responses.delete();
            in_flight = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response beat with none expected: read_data %0h irq_line %0b",
                           rsp.read_data, rsp.irq_line);
                    fail_total++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, rsp.read_data);
                        fail_total++;
                    end
                    if (rsp.irq_line !== want.irq_line)
                    begin
                        $error("irq_line: expected %0b, got %0b",
                               want.irq_line, rsp.irq_line);
                        fail_total++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                beat.operation = req.operation;
                beat.reg_offset = req.reg_offset;
                beat.write_data = req.write_data;
                beat.source_bit = req.source_bit;
                beat.source_level = req.source_level;
                beat.pad_a_buttons = req.pad_a_buttons;
                beat.pad_b_buttons = req.pad_b_buttons;
                update_register_page(beat, want);
                due_responses.push_back(want);
            end
            in_flight = due_responses.size();
        end
    end

endmodule

>>> tb/pad_shift_and_irq_registers_unit_test.sv
module pad_shift_and_irq_registers_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import psirq_pkg::*;

    // operation code the page has no name for: it must do nothing
    localparam logic [1:0] OP_NONE = 2'd3;
    // an offset that decodes to no register
    localparam logic [7:0] OFF_UNMAPPED = 8'hFF;

    localparam int    CLK_PERIOD = 10;
    localparam int    RESET_CYCLES = 6;
    localparam int    RANDOM_BEATS = 1680;
    localparam int    LONG_HOLD = 90;      // cycles the receiver sits with ready low
    localparam int    FLOOD_BEATS = 40;    // back-to-back beats offered during a hold
    localparam int    SETTLE_CYCLES = 8;   // margin beyond the two-stage pipeline
    localparam longint TIMEOUT_NS = 5_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   outstanding;
    int   hold_asked = 0;   // bumped by the sender to ask the receiver for a long hold

    psirq_req_if req_ch();
    psirq_rsp_if rsp_ch();

    pad_shift_and_irq_registers_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pad_shift_and_irq_registers_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // idle length: none at all in the busy stretches, otherwise mostly short with
    // the odd long gap
    function automatic int idle_gap(input bit sparse);
        int r;
        if (!sparse)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic req_item_t make_beat(input logic [1:0] op, input logic [7:0] offset,
                                            input logic [7:0] data, input logic [2:0] src,
                                            input logic level, input logic [15:0] pad_a,
                                            input logic [15:0] pad_b);
        req_item_t beat;
        beat.operation = op;
        beat.reg_offset = offset;
        beat.write_data = data;
        beat.source_bit = src;
        beat.source_level = level;
        beat.pad_a_buttons = pad_a;
        beat.pad_b_buttons = pad_b;
        return beat;
    endfunction

    // random bus traffic: mostly real register accesses and interrupt events,
    // with every field filled at random and a little pure noise on top
    function automatic req_item_t random_beat();
        req_item_t beat;
        int        kind;
        beat = make_beat(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         3'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // shift control: half the time keep the clear bits high so that
            // several shifts can pile up in a shift register
            beat.operation = OP_WRITE;
            beat.reg_offset = OFF_SHIFT_CTRL;
            if ($urandom_range(0, 1))
                beat.write_data[5:4] = 2'b11;
        end
        else if (kind < 45)
        begin
            beat.operation = OP_READ;
            beat.reg_offset = $urandom_range(0, 1) ? OFF_SHIFT1 : OFF_SHIFT0;
        end
        else if (kind < 53)
        begin
            beat.operation = OP_WRITE;
            beat.reg_offset = OFF_IRQ_EN;
        end
        else if (kind < 70)
            beat.operation = OP_EVENT;
        else if (kind < 78)
        begin
            beat.operation = OP_READ;
            beat.reg_offset = OFF_IRQ_SRC;
        end
        else if (kind < 83)
        begin
            beat.operation = OP_READ;
            beat.reg_offset = OFF_IRQ_EN;
        end
        else if (kind < 88)
        begin
            beat.operation = OP_WRITE;
            beat.reg_offset = $urandom_range(0, 1) ? OFF_SHIFT0 : OFF_IRQ_SRC;
        end
        // the rest stays as drawn: any operation at any offset
        return beat;
    endfunction

    // offer one beat after an optional gap and hold it until the page takes it;
    // valid is only lowered when a gap follows, so it never drops and rises in
    // the same step
    task automatic send_beat(input req_item_t beat, input int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.operation <= beat.operation;
        req_ch.reg_offset <= beat.reg_offset;
        req_ch.write_data <= beat.write_data;
        req_ch.source_bit <= beat.source_bit;
        req_ch.source_level <= beat.source_level;
        req_ch.pad_a_buttons <= beat.pad_a_buttons;
        req_ch.pad_b_buttons <= beat.pad_b_buttons;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // stop offering and wait until every predicted response has come back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // request side: reset, directed beats, then random traffic
    initial
    begin
        int gap;
        int flood;
        bit sparse;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_READ;
        req_ch.reg_offset <= '0;
        req_ch.write_data <= '0;
        req_ch.source_bit <= '0;
        req_ch.source_level <= 1'b0;
        req_ch.pad_a_buttons <= '0;
        req_ch.pad_b_buttons <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every readable register straight out of reset
        send_beat(make_beat(OP_READ, OFF_SHIFT0, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_SHIFT1, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF), 0);
        send_beat(make_beat(OP_READ, OFF_IRQ_EN, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_IRQ_SRC, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        // lowest and highest source bits, then enable everything: line goes high
        send_beat(make_beat(OP_EVENT, 8'h00, 8'h00, 3'd0, 1'b1, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_EVENT, 8'hFF, 8'hFF, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF), 0);
        send_beat(make_beat(OP_WRITE, OFF_IRQ_EN, 8'hFF, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        // clearing one bit by event, then reading the source clears the rest
        send_beat(make_beat(OP_EVENT, 8'h00, 8'h00, 3'd7, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_IRQ_SRC, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_WRITE, OFF_IRQ_EN, 8'h80, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_EVENT, 8'h00, 8'h00, 3'd7, 1'b1, 16'h0000, 16'h0000), 0);
        // latch each pad on its own falling bit, then shift both at once
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'h3F, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'h3E, 3'd0, 1'b0, 16'hFFFF, 16'h0000), 0);
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'h3D, 3'd0, 1'b0, 16'h0000, 16'h8001), 0);
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'h33, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_SHIFT0, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_SHIFT1, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        // all six bits fall together: latch, shift and clear in one write
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'hFF, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_WRITE, OFF_SHIFT_CTRL, 8'h00, 3'd0, 1'b0, 16'hFFFF, 16'hFFFF), 0);
        send_beat(make_beat(OP_READ, OFF_SHIFT0, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        // write-only control register reads as zero, unmapped offsets do nothing
        send_beat(make_beat(OP_READ, OFF_SHIFT_CTRL, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_WRITE, OFF_UNMAPPED, 8'hFF, 3'd0, 1'b0, 16'hFFFF, 16'hFFFF), 0);
        send_beat(make_beat(OP_READ, OFF_UNMAPPED, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        // the unnamed operation must neither read nor clear the source
        send_beat(make_beat(OP_NONE, OFF_IRQ_SRC, 8'hFF, 3'd7, 1'b0, 16'h0000, 16'h0000), 0);
        send_beat(make_beat(OP_READ, OFF_IRQ_SRC, 8'h00, 3'd0, 1'b0, 16'h0000, 16'h0000), 0);
        drain_responses();

        flood = 0;
        sparse = 1'b0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // now and then let the pipeline run dry before carrying on
            if (n % 400 == 200)
                drain_responses();
            // ask for a long receiver hold and flood the input meanwhile,
            // so the page fills up and pushes back on the request side
            if (n % 500 == 300)
            begin
                hold_asked <= hold_asked + 1;
                flood = FLOOD_BEATS;
            end
            if ($urandom_range(0, 149) == 0)
                sparse = !sparse;
            if (flood > 0)
            begin
                gap = 0;
                flood--;
            end
            else
                gap = idle_gap(sparse);
            send_beat(random_beat(), gap);
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // response side: random stalls, plus the long holds the sender asks for
    initial
    begin
        int stall;
        int holds_done;
        bit sparse;
        holds_done = 0;
        sparse = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_asked)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done = hold_asked;
            end
            if ($urandom_range(0, 149) == 0)
                sparse = !sparse;
            stall = idle_gap(sparse);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/psirq_pkg.sv
rtl/core/psirq_ifs.sv
rtl/core/psirq_regs.sv
rtl/core/pad_shift_and_irq_registers_unit.sv
tb/pad_shift_and_irq_registers_unit_checker.sv
tb/pad_shift_and_irq_registers_unit_test.sv
